/* design/twdot_pkg.sv */
// Shared types, constants and weight decode for the ternary-weight int8 dot block.
// No dependencies; imported by every module of the block.
package twdot_pkg;

    localparam int ACC_BITS_DEF        = 32;
    localparam int SCALE_FRAC_BITS_DEF = 24;
    localparam int QUEUE_DEPTH_DEF     = 4;

    localparam int ACT_BITS   = 8;
    localparam int PROD_BITS  = 10;
    localparam int SUM_BITS   = 11;
    localparam int TOTAL_BITS = 32;
    localparam int SCALE_BITS = 32;
    localparam int OUT_BITS   = 48;

    localparam logic [SCALE_BITS-1:0] SCALE_RESET = 32'd16777216;

    localparam logic [1:0] CODE_NEG  = 2'd0;
    localparam logic [1:0] CODE_ZERO = 2'd1;
    localparam logic [1:0] CODE_POS  = 2'd2;
    localparam logic [1:0] CODE_TWO  = 2'd3;

    typedef struct packed {
        logic signed [SUM_BITS-1:0] sum;
        logic                       row_end;
    } t_tw_entry;

    function automatic logic signed [PROD_BITS-1:0] weight_product(
        input logic [1:0]                 code,
        input logic signed [ACT_BITS-1:0] act
    );
        logic signed [PROD_BITS-1:0] a_ext;
        a_ext = PROD_BITS'(act);
        case (code)
            CODE_NEG:  weight_product = -a_ext;
            CODE_ZERO: weight_product = '0;
            CODE_POS:  weight_product = a_ext;
            CODE_TWO:  weight_product = a_ext <<< 1;
            default:   weight_product = '0;
        endcase
    endfunction

endpackage

/* design/twdot_front.sv */
// Front part: accepts input items and reduces the four weight products to one partial sum.
// Depends on twdot_pkg; feeds twdot_queue.
module twdot_front import twdot_pkg::*; (
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [7:0]                 i_weight_byte,
    input  logic signed [ACT_BITS-1:0] i_act_a,
    input  logic signed [ACT_BITS-1:0] i_act_b,
    input  logic signed [ACT_BITS-1:0] i_act_c,
    input  logic signed [ACT_BITS-1:0] i_act_d,
    input  logic                       i_row_end,
    input  logic                       i_q_full,
    output logic                       o_push,
    output t_tw_entry                  o_entry
);

    logic signed [PROD_BITS-1:0] p_a, p_b, p_c, p_d;

    assign p_a = weight_product(i_weight_byte[7:6], i_act_a);
    assign p_b = weight_product(i_weight_byte[5:4], i_act_b);
    assign p_c = weight_product(i_weight_byte[3:2], i_act_c);
    assign p_d = weight_product(i_weight_byte[1:0], i_act_d);

    assign o_in_stall      = i_q_full;
    assign o_push          = i_in_valid && !i_q_full;
    assign o_entry.sum     = SUM_BITS'(p_a) + SUM_BITS'(p_b) + SUM_BITS'(p_c) + SUM_BITS'(p_d);
    assign o_entry.row_end = i_row_end;

endmodule

/* design/twdot_queue.sv */
// Short FIFO of partial-sum items between the front and back parts.
// Depends on twdot_pkg for the entry type.
module twdot_queue import twdot_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_tw_entry i_entry,
    input  logic      i_pop,
    output logic      o_full,
    output logic      o_valid,
    output t_tw_entry o_entry
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_tw_entry         r_mem [DEPTH];
    logic [IW-1:0]     r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]     r_count;
    logic [IW-1:0]     n_wr_ptr, n_rd_ptr;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];

    assign n_wr_ptr = (r_wr_ptr == IW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == IW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* design/twdot_back.sv */
// Back part: row accumulator, scale register, scale multiply and output register.
// Depends on twdot_pkg; drains twdot_queue.
module twdot_back import twdot_pkg::*; #(
    parameter int ACC_BITS        = ACC_BITS_DEF,
    parameter int SCALE_FRAC_BITS = SCALE_FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_valid,
    input  t_tw_entry                    i_q_entry,
    output logic                         o_q_pop,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [SCALE_BITS-1:0]        i_cfg_data,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic signed [TOTAL_BITS-1:0] o_row_total,
    output logic signed [OUT_BITS-1:0]   o_row_scaled
);

    localparam int WIDE = (ACC_BITS > TOTAL_BITS) ? ACC_BITS : TOTAL_BITS;

    logic [SCALE_BITS-1:0]          r_scale;
    logic [ACC_BITS-1:0]            r_acc;
    logic [ACC_BITS-1:0]            n_acc;
    logic [WIDE-1:0]                n_acc_wide;
    logic                           r_s1_valid;
    logic signed [TOTAL_BITS-1:0]   r_s1_total;
    logic                           r_out_valid;
    logic signed [TOTAL_BITS-1:0]   r_out_total;
    logic signed [OUT_BITS-1:0]     r_out_scaled;
    logic                           en_out, en_s1;
    logic signed [TOTAL_BITS:0]     total_ext;
    logic signed [SCALE_BITS:0]     scale_ext;
    logic signed [TOTAL_BITS+SCALE_BITS+1:0] prod;
    logic signed [TOTAL_BITS+SCALE_BITS-1:0] prod64;
    logic signed [TOTAL_BITS+SCALE_BITS-1:0] shifted;

    assign en_out  = !r_out_valid || !i_out_stall;
    assign en_s1   = !r_s1_valid || en_out;
    assign o_q_pop = i_q_valid && (!i_q_entry.row_end || en_s1);

    assign n_acc      = r_acc + {{(ACC_BITS - SUM_BITS){i_q_entry.sum[SUM_BITS-1]}},
                                 i_q_entry.sum};
    assign n_acc_wide = WIDE'(n_acc);

    assign total_ext = {r_s1_total[TOTAL_BITS-1], r_s1_total};
    assign scale_ext = {1'b0, r_scale};
    assign prod      = total_ext * scale_ext;
    assign prod64    = prod[TOTAL_BITS+SCALE_BITS-1:0];
    assign shifted   = prod64 >>> SCALE_FRAC_BITS;

    assign o_cfg_ready  = 1'b1;
    assign o_out_valid  = r_out_valid;
    assign o_row_total  = r_out_total;
    assign o_row_scaled = r_out_scaled;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale     <= SCALE_RESET;
            r_acc       <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_scale <= i_cfg_data;
            end
            if (o_q_pop) begin
                r_acc <= i_q_entry.row_end ? '0 : n_acc;
            end
            if (en_s1) begin
                r_s1_valid <= o_q_pop && i_q_entry.row_end;
            end
            if (en_out) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop && i_q_entry.row_end) begin
            r_s1_total <= n_acc_wide[TOTAL_BITS-1:0];
        end
        if (en_out && r_s1_valid) begin
            r_out_total  <= r_s1_total;
            r_out_scaled <= shifted[OUT_BITS-1:0];
        end
    end

endmodule

/* design/ternary_weight_int8_dot.sv */
// Top level of the ternary-weight int8 row dot product.
// Depends on twdot_pkg, twdot_front, twdot_queue and twdot_back.
//
// Input channel (i_in_valid / o_in_stall): one item per cycle, a packed weight
// byte with its four int8 activations and a row_end flag. Items are taken at
// one per cycle while the queue has room; o_in_stall rises only once the queue
// is full, which happens only while the result side is stalled.
// Output channel (o_out_valid / i_out_stall): one item per row, the 32-bit
// wrapped total and the total times row_scale shifted right by the fraction
// width. After its last byte is taken, the result of a row passes through the
// two-stage back end (accumulate, then scale multiply into the output
// register). Sustained rate is one input item per cycle while the result
// side does not stall.
// Config channel (i_cfg_valid / o_cfg_ready): writes row_scale, always ready.
// Write it only while the block is idle.
// Reset (synchronous, active low) clears the accumulator, empties the queue
// and pipeline, and sets row_scale to 1.0. While i_out_stall is high the
// result holds, the back end keeps summing bytes that do not end a row, and
// the queue absorbs up to its depth before the input stalls.
module ternary_weight_int8_dot import twdot_pkg::*; #(
    parameter int ACC_BITS        = ACC_BITS_DEF,
    parameter int SCALE_FRAC_BITS = SCALE_FRAC_BITS_DEF,
    parameter int QUEUE_DEPTH     = QUEUE_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [7:0]                   i_weight_byte,
    input  logic signed [ACT_BITS-1:0]   i_act_a,
    input  logic signed [ACT_BITS-1:0]   i_act_b,
    input  logic signed [ACT_BITS-1:0]   i_act_c,
    input  logic signed [ACT_BITS-1:0]   i_act_d,
    input  logic                         i_row_end,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic signed [TOTAL_BITS-1:0] o_row_total,
    output logic signed [OUT_BITS-1:0]   o_row_scaled,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [SCALE_BITS-1:0]        i_cfg_data
);

    logic      q_full, q_valid, q_push, q_pop;
    t_tw_entry push_entry, head_entry;

    twdot_front u_front (
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_weight_byte (i_weight_byte),
        .i_act_a       (i_act_a),
        .i_act_b       (i_act_b),
        .i_act_c       (i_act_c),
        .i_act_d       (i_act_d),
        .i_row_end     (i_row_end),
        .i_q_full      (q_full),
        .o_push        (q_push),
        .o_entry       (push_entry)
    );

    twdot_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (push_entry),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_entry (head_entry)
    );

    twdot_back #(
        .ACC_BITS        (ACC_BITS),
        .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_entry    (head_entry),
        .o_q_pop      (q_pop),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_row_total  (o_row_total),
        .o_row_scaled (o_row_scaled)
    );

endmodule

/* design/twdot_checker.sv */
// Port-level checks for ternary_weight_int8_dot, attached by the bind below.
// Depends on twdot_pkg for field widths.
module twdot_checker import twdot_pkg::*; (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_in_stall,
    input logic                         o_out_valid,
    input logic                         i_out_stall,
    input logic signed [TOTAL_BITS-1:0] o_row_total,
    input logic signed [OUT_BITS-1:0]   o_row_scaled
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result item dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_row_total) && $stable(o_row_scaled))
        else $error("result item changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("block not empty after reset");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(o_out_valid && i_out_stall))
        else $error("input stalled without a stalled result");

endmodule

bind ternary_weight_int8_dot twdot_checker u_twdot_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_row_total  (o_row_total),
    .o_row_scaled (o_row_scaled)
);
